@@ hdl/arc_pkg.sv @@
// Shared types, codes and defaults for the adaptive replacement cache.
`default_nettype none

package arc_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [1:0] OP_GET   = 2'd0;
    localparam logic [1:0] OP_PUT   = 2'd1;
    localparam logic [1:0] OP_ERASE = 2'd2;

    typedef enum logic [2:0] {
        L_EMPTY = 3'd0,
        L_T1    = 3'd1,
        L_T2    = 3'd2,
        L_B1    = 3'd3,
        L_B2    = 3'd4
    } list_t;

    typedef enum logic [1:0] {
        DIR_NONE   = 2'd0,
        DIR_UNLINK = 2'd1,
        DIR_LINK   = 2'd2
    } dir_op_t;

    typedef enum logic [1:0] {
        M_DEL    = 2'd0,
        M_DEMOTE = 2'd1,
        M_DROP   = 2'd2
    } lru_mode_t;

    // Position of a list in the length table.
    function automatic logic [1:0] len_idx(input list_t l);
        logic [2:0] t;
        t = 3'(l) - 3'd1;
        return t[1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/arc_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module arc_div #(
    parameter int W = 6
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] num,
    input  wire logic [W-1:0] den,
    output logic              done,
    output logic [W-1:0]      quot
);
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     q_reg, q_next;
    logic [W-1:0]     den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [W:0]       shifted;
    logic [W:0]       diff;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, q_reg[W-1]};
        diff      = shifted - {1'b0, den_reg};
        if (start)
        begin
            rem_next = '0;
            q_next   = num;
            den_next = den;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                q_next   = {q_reg[W-2+1-1:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                q_next   = {q_reg[W-2+1-1:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

@@ hdl/arc_dir.sv @@
// Directory of list tags, recency ranks and list lengths.
`default_nettype none

module arc_dir #(
    parameter int SLOTS = 32,
    parameter int IDX_W = 5,
    parameter int LEN_W = 6
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire arc_pkg::dir_op_t       dir_op,
    input  wire logic [IDX_W-1:0]       dir_slot,
    input  wire arc_pkg::list_t         dir_list,
    input  wire logic [IDX_W-1:0]       q_idx,
    output arc_pkg::list_t              q_list,
    output logic [IDX_W-1:0]            q_rank,
    output logic [3:0][LEN_W-1:0]       lengths
);
    import arc_pkg::*;

    list_t            list_reg [SLOTS];
    logic [IDX_W-1:0] rank_reg [SLOTS];
    logic [LEN_W-1:0] len_reg  [4];
    list_t            cur;

    assign cur = list_reg[dir_slot];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                list_reg[i] <= L_EMPTY;
                rank_reg[i] <= '0;
            end
            for (int j = 0; j < 4; j++)
            begin
                len_reg[j] <= '0;
            end
        end
        else
        begin
            case (dir_op)
                DIR_UNLINK:
                begin
                    if (cur != L_EMPTY)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (list_reg[i] == cur && rank_reg[i] > rank_reg[dir_slot])
                            begin
                                rank_reg[i] <= rank_reg[i] - 1'b1;
                            end
                        end
                        len_reg[len_idx(cur)] <= len_reg[len_idx(cur)] - 1'b1;
                        list_reg[dir_slot]    <= L_EMPTY;
                        rank_reg[dir_slot]    <= '0;
                    end
                end
                DIR_LINK:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (list_reg[i] == dir_list)
                        begin
                            rank_reg[i] <= rank_reg[i] + 1'b1;
                        end
                    end
                    list_reg[dir_slot]         <= dir_list;
                    rank_reg[dir_slot]         <= '0;
                    len_reg[len_idx(dir_list)] <= len_reg[len_idx(dir_list)] + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign q_list = list_reg[q_idx];
    assign q_rank = rank_reg[q_idx];

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            lengths[j] = len_reg[j];
        end
    end

endmodule

`default_nettype wire

@@ hdl/arc_replacement_cache.sv @@
// Top level of the adaptive replacement cache: sequencer, key and value memories.
`default_nettype none

// Usage
// A request (operation, key, value_in) is transferred at a rising edge where
// start is high and busy is low. busy then stays high until the result has
// been shown. The result (hit, value_out, evicted_valid, victim_key and the
// three running totals) is valid for exactly one cycle while done is high;
// the receiver cannot stall, so it must take the result in that cycle.
// Only one request is in flight at a time. The directory is walked one slot
// per cycle by a single compare path: once for the key lookup, and once more
// for each LRU choice or free-slot search. A ghost hit adds a six-step ratio
// division. cfg_write loads the capacity register (0 acts as 1, values above
// CAPACITY act as CAPACITY); the user must write it only while the block is
// idle, as the block itself does not enforce this. Reset clears every list,
// length, the target p and all counters and sets the capacity register to 16;
// key and value storage keeps no reset and is only read for slots that the
// directory marks as in use.
module arc_replacement_cache #(
    parameter int CAPACITY   = arc_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = arc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = arc_pkg::VALUE_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                operation,
    input  wire logic [KEY_BITS-1:0]       key,
    input  wire logic [VALUE_BITS-1:0]     value_in,
    input  wire logic                      cfg_write,
    input  wire logic [arc_pkg::CAP_W-1:0] cfg_data,
    output logic                           done,
    output logic                           hit,
    output logic [VALUE_BITS-1:0]          value_out,
    output logic                           evicted_valid,
    output logic [KEY_BITS-1:0]            victim_key,
    output logic [31:0]                    hit_total,
    output logic [31:0]                    miss_total,
    output logic [31:0]                    eviction_total
);
    import arc_pkg::*;

    localparam int SLOTS = 2 * CAPACITY;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int LEN_W = $clog2(SLOTS + 1);
    localparam int SUM_W = LEN_W + 2;

    typedef enum logic [14:0] {
        S_IDLE      = 15'h0001,
        S_KEY       = 15'h0002,
        S_DISPATCH  = 15'h0004,
        S_MOVE      = 15'h0008,
        S_DIV       = 15'h0010,
        S_REPCHK    = 15'h0020,
        S_LRU_SCAN  = 15'h0040,
        S_LRU_UNLNK = 15'h0080,
        S_LRU_LINK  = 15'h0100,
        S_AFTER     = 15'h0200,
        S_GLINK     = 15'h0400,
        S_FREE      = 15'h0800,
        S_INSERT    = 15'h1000,
        S_FIN       = 15'h2000,
        S_SPARE     = 15'h4000
    } state_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [CAP_W-1:0]    cap_reg;
    logic [1:0]          op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [LEN_W-1:0]    c_reg, c_next, c_clamp;
    logic [LEN_W-1:0]    p_reg, p_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    s_reg, s_next;
    logic [IDX_W-1:0]    lru_reg, lru_next;
    list_t               lru_list_reg, lru_list_next;
    lru_mode_t           mode_reg, mode_next;
    logic                inb2_reg, inb2_next;
    logic                ghost_reg, ghost_next;
    logic                retry_reg, retry_next;
    logic                hit_reg, hit_next;
    logic [VALUE_BITS-1:0] vout_reg, vout_next;
    logic                evv_reg, evv_next;
    logic [KEY_BITS-1:0] evk_reg, evk_next;
    logic [31:0]         hitc_reg, hitc_next;
    logic [31:0]         missc_reg, missc_next;
    logic [31:0]         evc_reg, evc_next;

    dir_op_t             dir_op;
    logic [IDX_W-1:0]    dir_slot;
    list_t               dir_list;
    logic [IDX_W-1:0]    q_idx;
    list_t               q_list;
    logic [IDX_W-1:0]    q_rank;
    logic [3:0][LEN_W-1:0] lengths;
    logic [LEN_W-1:0]    t1, t2, b1, b2, lru_len, div_den_now;

    logic                div_start, div_done;
    logic [LEN_W-1:0]    div_num, div_den, div_quot, d_val;
    logic [SUM_W-1:0]    p_sum;

    logic                take_t1;
    list_t               rep_list;
    logic [SUM_W-1:0]    sum_t1b1, sum_res, sum_all, two_c;

    // Key and value storage.
    logic [KEY_BITS-1:0]   key_mem [SLOTS];
    logic [VALUE_BITS-1:0] val_mem [SLOTS];
    logic [KEY_BITS-1:0]   key_rd;
    logic [VALUE_BITS-1:0] val_rd;
    logic [IDX_W-1:0]      key_addr;
    logic                  key_we, val_we;

    assign key_addr = (state_reg == S_KEY) ? idx_reg[IDX_W-1:0] : lru_reg;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[s_reg] <= key_reg;
        end
        if (val_we)
        begin
            val_mem[s_reg] <= val_reg;
        end
        key_rd <= key_mem[key_addr];
        val_rd <= val_mem[s_reg];
    end

    arc_dir #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W),
        .LEN_W (LEN_W)
    ) u_dir (
        .clk      (clk),
        .rst_n    (rst_n),
        .dir_op   (dir_op),
        .dir_slot (dir_slot),
        .dir_list (dir_list),
        .q_idx    (q_idx),
        .q_list   (q_list),
        .q_rank   (q_rank),
        .lengths  (lengths)
    );

    arc_div #(
        .W (LEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign t1 = lengths[len_idx(L_T1)];
    assign t2 = lengths[len_idx(L_T2)];
    assign b1 = lengths[len_idx(L_B1)];
    assign b2 = lengths[len_idx(L_B2)];
    assign lru_len = lengths[len_idx(lru_list_reg)];

    // The clamped capacity that a new request works with.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            c_clamp = LEN_W'(1);
        end
        else if (int'(cap_reg) > CAPACITY)
        begin
            c_clamp = LEN_W'(CAPACITY);
        end
        else
        begin
            c_clamp = LEN_W'(cap_reg);
        end
    end

    assign sum_t1b1 = SUM_W'(t1) + SUM_W'(b1);
    assign sum_res  = SUM_W'(t1) + SUM_W'(t2);
    assign sum_all  = sum_res + SUM_W'(b1) + SUM_W'(b2);
    assign two_c    = SUM_W'(c_reg) << 1;

    // REPLACE picks T1 when it is non-empty and over target or at target on a B2 hit, and also when T2 is empty.
    assign take_t1  = (t1 != '0) && ((t1 > p_reg) || (inb2_reg && (t1 == p_reg)));
    assign rep_list = (take_t1 || (t2 == '0)) ? L_T1 : L_T2;

    assign div_den_now = inb2_reg ? b2 : b1;
    assign d_val = ((div_den_now == '0) || (div_quot == '0)) ? LEN_W'(1) : div_quot;
    assign p_sum = SUM_W'(p_reg) + SUM_W'(d_val);

    always_comb
    begin
        case (state_reg)
            S_KEY:      q_idx = pidx_reg;
            S_LRU_SCAN: q_idx = idx_reg[IDX_W-1:0];
            S_FREE:     q_idx = idx_reg[IDX_W-1:0];
            default:    q_idx = s_reg;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        c_next        = c_reg;
        p_next        = p_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        found_next    = found_reg;
        s_next        = s_reg;
        lru_next      = lru_reg;
        lru_list_next = lru_list_reg;
        mode_next     = mode_reg;
        inb2_next     = inb2_reg;
        ghost_next    = ghost_reg;
        retry_next    = retry_reg;
        hit_next      = hit_reg;
        vout_next     = vout_reg;
        evv_next      = evv_reg;
        evk_next      = evk_reg;
        hitc_next     = hitc_reg;
        missc_next    = missc_reg;
        evc_next      = evc_reg;
        dir_op        = DIR_NONE;
        dir_slot      = s_reg;
        dir_list      = L_EMPTY;
        key_we        = 1'b0;
        val_we        = 1'b0;
        div_start     = 1'b0;
        div_num       = b2;
        div_den       = b1;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    key_next   = key;
                    val_next   = value_in;
                    c_next     = c_clamp;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    hit_next   = 1'b0;
                    vout_next  = '0;
                    evv_next   = 1'b0;
                    evk_next   = '0;
                    retry_next = 1'b0;
                    inb2_next  = 1'b0;
                    ghost_next = 1'b0;
                    state_next = S_KEY;
                end
            end

            // One slot per cycle: the key read of a slot is registered and compared while the next slot is read.
            S_KEY:
            begin
                if (pend_reg && (q_list != L_EMPTY) && (key_rd == key_reg))
                begin
                    found_next = 1'b1;
                    s_next     = pidx_reg;
                    state_next = S_DISPATCH;
                end
                else if (idx_reg == CNT_W'(SLOTS))
                begin
                    found_next = 1'b0;
                    state_next = S_DISPATCH;
                end
                else
                begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
            end

            S_DISPATCH:
            begin
                if (op_reg == OP_ERASE)
                begin
                    if (found_reg)
                    begin
                        hit_next = (q_list == L_T1) || (q_list == L_T2);
                        dir_op   = DIR_UNLINK;
                    end
                    state_next = S_FIN;
                end
                else if (found_reg && ((q_list == L_T1) || (q_list == L_T2)))
                begin
                    hit_next  = 1'b1;
                    hitc_next = sat_inc(hitc_reg);
                    dir_op    = DIR_UNLINK;
                    if (op_reg == OP_PUT)
                    begin
                        val_we = 1'b1;
                    end
                    state_next = S_MOVE;
                end
                else if (op_reg != OP_PUT)
                begin
                    missc_next = sat_inc(missc_reg);
                    state_next = S_FIN;
                end
                else if (found_reg)
                begin
                    // Ghost hit: adapt p by the ratio of the ghost list sizes.
                    missc_next = sat_inc(missc_reg);
                    ghost_next = 1'b1;
                    inb2_next  = (q_list == L_B2);
                    div_start  = 1'b1;
                    if (q_list == L_B2)
                    begin
                        div_num = b1;
                        div_den = b2;
                    end
                    state_next = S_DIV;
                end
                else
                begin
                    // New key.
                    missc_next = sat_inc(missc_reg);
                    idx_next   = '0;
                    if (sum_t1b1 >= SUM_W'(c_reg))
                    begin
                        if (t1 < c_reg)
                        begin
                            if (b1 != '0)
                            begin
                                lru_list_next = L_B1;
                                mode_next     = M_DEL;
                                ret_next      = S_REPCHK;
                                state_next    = S_LRU_SCAN;
                            end
                            else
                            begin
                                state_next = S_REPCHK;
                            end
                        end
                        else if (t1 != '0)
                        begin
                            lru_list_next = L_T1;
                            mode_next     = M_DROP;
                            ret_next      = S_FREE;
                            state_next    = S_LRU_SCAN;
                        end
                        else
                        begin
                            state_next = S_FREE;
                        end
                    end
                    else if (sum_all >= SUM_W'(c_reg))
                    begin
                        if ((sum_all >= two_c) && (b2 != '0))
                        begin
                            lru_list_next = L_B2;
                            mode_next     = M_DEL;
                            ret_next      = S_REPCHK;
                            state_next    = S_LRU_SCAN;
                        end
                        else
                        begin
                            state_next = S_REPCHK;
                        end
                    end
                    else
                    begin
                        state_next = S_FREE;
                    end
                end
            end

            S_MOVE:
            begin
                dir_op   = DIR_LINK;
                dir_list = L_T2;
                if (op_reg != OP_PUT)
                begin
                    vout_next = val_rd;
                end
                state_next = S_FIN;
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    if (!inb2_reg)
                    begin
                        p_next = (p_sum > SUM_W'(c_reg)) ? c_reg : p_sum[LEN_W-1:0];
                    end
                    else
                    begin
                        p_next = (p_reg > d_val) ? p_reg - d_val : '0;
                    end
                    state_next = S_REPCHK;
                end
            end

            S_REPCHK:
            begin
                idx_next = '0;
                if ((sum_res >= SUM_W'(c_reg)) && ((t1 != '0) || (t2 != '0)))
                begin
                    lru_list_next = rep_list;
                    mode_next     = M_DEMOTE;
                    ret_next      = S_AFTER;
                    state_next    = S_LRU_SCAN;
                end
                else
                begin
                    state_next = S_AFTER;
                end
            end

            S_LRU_SCAN:
            begin
                if ((q_list == lru_list_reg) && (q_rank == IDX_W'(lru_len - 1'b1)))
                begin
                    lru_next   = idx_reg[IDX_W-1:0];
                    state_next = S_LRU_UNLNK;
                end
                else if (idx_reg == CNT_W'(SLOTS - 1))
                begin
                    idx_next   = '0;
                    state_next = ret_reg;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_LRU_UNLNK:
            begin
                dir_op     = DIR_UNLINK;
                dir_slot   = lru_reg;
                state_next = S_LRU_LINK;
            end

            S_LRU_LINK:
            begin
                dir_slot = lru_reg;
                if (mode_reg == M_DEMOTE)
                begin
                    dir_op   = DIR_LINK;
                    dir_list = (lru_list_reg == L_T1) ? L_B1 : L_B2;
                end
                if (mode_reg != M_DEL)
                begin
                    evv_next = 1'b1;
                    evk_next = key_rd;
                    evc_next = sat_inc(evc_reg);
                end
                idx_next   = '0;
                state_next = ret_reg;
            end

            S_AFTER:
            begin
                idx_next = '0;
                if (ghost_reg)
                begin
                    dir_op     = DIR_UNLINK;
                    state_next = S_GLINK;
                end
                else
                begin
                    state_next = S_FREE;
                end
            end

            S_GLINK:
            begin
                val_we     = 1'b1;
                dir_op     = DIR_LINK;
                dir_list   = L_T2;
                state_next = S_FIN;
            end

            S_FREE:
            begin
                if (q_list == L_EMPTY)
                begin
                    s_next     = idx_reg[IDX_W-1:0];
                    state_next = S_INSERT;
                end
                else if (idx_reg == CNT_W'(SLOTS - 1))
                begin
                    // Directory full: unless already retried or no ghost exists, drop a ghost and search once more.
                    idx_next = '0;
                    if (retry_reg || ((b1 == '0) && (b2 == '0)))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        retry_next    = 1'b1;
                        lru_list_next = (b2 != '0) ? L_B2 : L_B1;
                        mode_next     = M_DEL;
                        ret_next      = S_FREE;
                        state_next    = S_LRU_SCAN;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_INSERT:
            begin
                key_we     = 1'b1;
                val_we     = 1'b1;
                dir_op     = DIR_LINK;
                dir_list   = L_T1;
                state_next = S_FIN;
            end

            S_FIN:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            cap_reg   <= CAP_RESET;
            p_reg     <= '0;
            hitc_reg  <= '0;
            missc_reg <= '0;
            evc_reg   <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            retry_reg <= 1'b0;
            ghost_reg <= 1'b0;
            inb2_reg  <= 1'b0;
            mode_reg  <= M_DEL;
            hit_reg   <= 1'b0;
            evv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
            p_reg     <= p_next;
            hitc_reg  <= hitc_next;
            missc_reg <= missc_next;
            evc_reg   <= evc_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            retry_reg <= retry_next;
            ghost_reg <= ghost_next;
            inb2_reg  <= inb2_next;
            mode_reg  <= mode_next;
            hit_reg   <= hit_next;
            evv_reg   <= evv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        c_reg        <= c_next;
        pidx_reg     <= pidx_next;
        s_reg        <= s_next;
        lru_reg      <= lru_next;
        lru_list_reg <= lru_list_next;
        vout_reg     <= vout_next;
        evk_reg      <= evk_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = (state_reg == S_FIN);
    assign hit            = hit_reg;
    assign value_out      = vout_reg;
    assign evicted_valid  = evv_reg;
    assign victim_key     = evk_reg;
    assign hit_total      = hitc_reg;
    assign miss_total     = missc_reg;
    assign eviction_total = evc_reg;

    // A result is only shown while a request is being worked on.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe outside a request");

    // An accepted request raises busy at once.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without busy");

    // The result strobe is never high back to back.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // A reported eviction is always counted.
    a_evict_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted_valid) |-> (eviction_total != 32'd0))
        else $error("eviction reported but not counted");

endmodule

`default_nettype wire

@@ sim/arc_checker.sv @@
// Checker for the adaptive replacement cache: predicts each result and compares it.
module arc_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] key,
    input  wire logic [31:0] value_in,
    input  wire logic        cfg_write,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        done,
    input  wire logic        hit,
    input  wire logic [31:0] value_out,
    input  wire logic        evicted_valid,
    input  wire logic [31:0] victim_key,
    input  wire logic [31:0] hit_total,
    input  wire logic [31:0] miss_total,
    input  wire logic [31:0] eviction_total,
    output int               fail_count,
    output int               pending
);
    import arc_pkg::*;

    localparam int SLOTS = 2 * CAPACITY_DEF;

    typedef struct packed {
        logic        hit;
        logic [31:0] value;
        logic        ev_valid;
        logic [31:0] ev_key;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
    } lookup_result_t;

    // Shadow copy of the directory.
    logic [31:0] slot_key [SLOTS];
    logic [31:0] slot_val [SLOTS];
    list_t       slot_list[SLOTS];
    int          slot_rank[SLOTS];
    int          list_len [5];
    int          target;
    logic [31:0] hit_cnt, miss_cnt, evict_cnt;
    logic [4:0]  capacity_reg;
    logic        ev_seen;
    logic [31:0] ev_tag;

    lookup_result_t expected_results[$];

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic int find_key(input logic [31:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (slot_list[i] != L_EMPTY && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int find_lru(input list_t l);
        if (list_len[l] == 0)
            return -1;
        for (int i = 0; i < SLOTS; i++)
            if (slot_list[i] == l && slot_rank[i] == list_len[l] - 1)
                return i;
        return -1;
    endfunction

    function automatic int find_free();
        for (int i = 0; i < SLOTS; i++)
            if (slot_list[i] == L_EMPTY)
                return i;
        return -1;
    endfunction

    function automatic void unlink_slot(input int s);
        list_t l;
        l = slot_list[s];
        if (l == L_EMPTY)
            return;
        for (int i = 0; i < SLOTS; i++)
            if (slot_list[i] == l && slot_rank[i] > slot_rank[s])
                slot_rank[i]--;
        list_len[l]--;
        slot_list[s] = L_EMPTY;
        slot_rank[s] = 0;
    endfunction

    function automatic void link_front(input int s, input list_t l);
        for (int i = 0; i < SLOTS; i++)
            if (slot_list[i] == l)
                slot_rank[i]++;
        slot_list[s] = l;
        slot_rank[s] = 0;
        list_len[l]++;
    endfunction

    function automatic void record_eviction(input logic [31:0] k);
        ev_seen = 1'b1;
        ev_tag = k;
        evict_cnt = sat_inc(evict_cnt);
    endfunction

    function automatic void drop_lru(input list_t l);
        int s;
        s = find_lru(l);
        if (s >= 0)
            unlink_slot(s);
    endfunction

    // Demotes one resident entry to its ghost list, following the ARC tie rule.
    function automatic void demote_one(input logic in_b2);
        list_t from;
        int s;
        from = L_T2;
        if (list_len[L_T1] >= 1 && (list_len[L_T1] > target ||
                                    (in_b2 && list_len[L_T1] == target)))
            from = L_T1;
        if (list_len[from] == 0)
            from = (from == L_T1) ? L_T2 : L_T1;
        s = find_lru(from);
        if (s < 0)
            return;
        unlink_slot(s);
        link_front(s, (from == L_T1) ? L_B1 : L_B2);
        record_eviction(slot_key[s]);
    endfunction

    function automatic lookup_result_t arc_lookup(input logic [1:0] op,
                                                  input logic [31:0] k,
                                                  input logic [31:0] v);
        lookup_result_t r;
        int c, s, t1, t2, b1, b2, d;
        logic resident, in_b2;
        c = int'(capacity_reg);
        if (c < 1)
            c = 1;
        if (c > CAPACITY_DEF)
            c = CAPACITY_DEF;
        r = '0;
        ev_seen = 1'b0;
        ev_tag = '0;
        s = find_key(k);
        resident = (s >= 0) && (slot_list[s] == L_T1 || slot_list[s] == L_T2);
        if (op == OP_ERASE) begin
            r.hit = resident;
            if (s >= 0)
                unlink_slot(s);
        end else if (op != OP_PUT) begin
            if (resident) begin
                r.hit = 1'b1;
                r.value = slot_val[s];
                unlink_slot(s);
                link_front(s, L_T2);
                hit_cnt = sat_inc(hit_cnt);
            end else begin
                miss_cnt = sat_inc(miss_cnt);
            end
        end else if (resident) begin
            r.hit = 1'b1;
            slot_val[s] = v;
            unlink_slot(s);
            link_front(s, L_T2);
            hit_cnt = sat_inc(hit_cnt);
        end else if (s >= 0) begin
            // Ghost hit: adapt the target toward the list that was hit.
            b1 = list_len[L_B1];
            b2 = list_len[L_B2];
            in_b2 = (slot_list[s] == L_B2);
            miss_cnt = sat_inc(miss_cnt);
            if (!in_b2) begin
                d = (b1 != 0) ? b2 / b1 : 0;
                if (d < 1)
                    d = 1;
                target = (target + d > c) ? c : target + d;
            end else begin
                d = (b2 != 0) ? b1 / b2 : 0;
                if (d < 1)
                    d = 1;
                target = (target > d) ? target - d : 0;
            end
            if (list_len[L_T1] + list_len[L_T2] >= c)
                demote_one(in_b2);
            unlink_slot(s);
            slot_val[s] = v;
            link_front(s, L_T2);
        end else begin
            t1 = list_len[L_T1];
            t2 = list_len[L_T2];
            b1 = list_len[L_B1];
            b2 = list_len[L_B2];
            miss_cnt = sat_inc(miss_cnt);
            if (t1 + b1 >= c) begin
                if (t1 < c) begin
                    drop_lru(L_B1);
                    if (list_len[L_T1] + list_len[L_T2] >= c)
                        demote_one(1'b0);
                end else begin
                    d = find_lru(L_T1);
                    if (d >= 0) begin
                        unlink_slot(d);
                        record_eviction(slot_key[d]);
                    end
                end
            end else if (t1 + t2 + b1 + b2 >= c) begin
                if (t1 + t2 + b1 + b2 >= 2 * c)
                    drop_lru(L_B2);
                if (list_len[L_T1] + list_len[L_T2] >= c)
                    demote_one(1'b0);
            end
            s = find_free();
            if (s < 0) begin
                if (list_len[L_B2] != 0)
                    drop_lru(L_B2);
                else
                    drop_lru(L_B1);
                s = find_free();
            end
            if (s >= 0) begin
                slot_key[s] = k;
                slot_val[s] = v;
                link_front(s, L_T1);
            end
        end
        r.ev_valid = ev_seen;
        r.ev_key = ev_seen ? ev_tag : 32'd0;
        r.hits = hit_cnt;
        r.misses = miss_cnt;
        r.evictions = evict_cnt;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        lookup_result_t want;
        logic [31:0] exp_f[7];
        logic [31:0] got_f[7];
        string names[7];
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_key[i] = '0;
                slot_val[i] = '0;
                slot_list[i] = L_EMPTY;
                slot_rank[i] = 0;
            end
            for (int i = 0; i < 5; i++)
                list_len[i] = 0;
            target = 0;
            hit_cnt = '0;
            miss_cnt = '0;
            evict_cnt = '0;
            capacity_reg = CAP_RESET;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (cfg_write)
                capacity_reg = cfg_data;
            if (done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no request outstanding", $realtime);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    names = '{"hit", "value_out", "evicted_valid", "victim_key",
                              "hit_total", "miss_total", "eviction_total"};
                    exp_f = '{32'(want.hit), want.value, 32'(want.ev_valid), want.ev_key,
                              want.hits, want.misses, want.evictions};
                    got_f = '{32'(hit), value_out, 32'(evicted_valid), victim_key,
                              hit_total, miss_total, eviction_total};
                    for (int f = 0; f < 7; f++)
                        if (got_f[f] !== exp_f[f]) begin
                            $display("%0t: %s mismatch, expected %h actual %h",
                                     $realtime, names[f], exp_f[f], got_f[f]);
                            fail_count++;
                        end
                end
            end
            // A request transfer is predicted after the result check of the same edge.
            if (start && !busy)
                expected_results.push_back(arc_lookup(operation, key, value_in));
            pending = expected_results.size();
        end
    end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the adaptive replacement cache: stimulus, watchdog and verdict.
module tb_top;
    import arc_pkg::*;

    // Idle time after the last result; it covers the longest request with margin.
    localparam int SETTLE = 250;
    // Cycles with no transfer of any kind before the run is declared hung.
    localparam int STALL_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  operation = '0;
    logic [31:0] key = '0;
    logic [31:0] value_in = '0;
    logic        cfg_write = 1'b0;
    logic [4:0]  cfg_data = '0;
    logic        busy, done, hit, evicted_valid;
    logic [31:0] value_out, victim_key, hit_total, miss_total, eviction_total;
    int          fail_count, pending;
    int          quiet_cycles = 0;

    // Pool of keys that requests draw from; a small pool forces hits and ghost hits.
    logic [31:0] key_pool[40];
    int          idle_pct;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    arc_replacement_cache u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .key(key), .value_in(value_in),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .done(done), .hit(hit), .value_out(value_out),
        .evicted_valid(evicted_valid), .victim_key(victim_key),
        .hit_total(hit_total), .miss_total(miss_total),
        .eviction_total(eviction_total)
    );

    arc_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .key(key), .value_in(value_in),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .done(done), .hit(hit), .value_out(value_out),
        .evicted_valid(evicted_valid), .victim_key(victim_key),
        .hit_total(hit_total), .miss_total(miss_total),
        .eviction_total(eviction_total),
        .fail_count(fail_count), .pending(pending)
    );

    // The watchdog restarts on every request transfer and every result.
    always @(posedge clk)
    begin
        if (rst_n && !((start && !busy) || done)) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end else begin
            quiet_cycles <= 0;
        end
    end

    // Presents one request and holds it until the block takes it. start stays
    // high on return so that a following request can be presented without lowering it first.
    task automatic issue(input logic [1:0] op, input logic [31:0] k, input logic [31:0] v);
        start <= 1'b1;
        operation <= op;
        key <= k;
        value_in <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drops start for a random number of cycles, at the configured rate.
    task automatic maybe_idle();
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Waits until every outstanding result has come and the block has settled.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [4:0] c);
        cfg_write <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Random traffic over a pool of pool_size keys. Puts and gets dominate so
    // that the lists fill, ghosts build up and the target p moves both ways.
    task automatic random_phase(input int count, input int pool_size);
        int pick;
        logic [1:0] op;
        for (int i = 0; i < pool_size; i++)
            key_pool[i] = $urandom();
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45)
                op = OP_PUT;
            else if (pick < 80)
                op = OP_GET;
            else if (pick < 92)
                op = OP_ERASE;
            else
                op = 2'd3;
            // Occasionally a key outside the pool, so every key bit moves freely.
            if ($urandom_range(19) == 0)
                issue(op, $urandom(), $urandom());
            else
                issue(op, key_pool[$urandom_range(pool_size - 1)], $urandom());
            // Halfway through, hold off until the block has nothing in flight.
            if (n == count / 2) begin
                start <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            maybe_idle();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with a tiny cache so that every list is reached fast.
        idle_pct = 31;
        set_capacity(5'd2);
        issue(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        issue(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        issue(OP_GET, 32'h0000_0000, 32'h0);       // get hit, moves to T2
        issue(OP_GET, 32'h1234_5678, 32'h0);       // get miss
        issue(2'd3, 32'hFFFF_FFFF, 32'h0);         // unused code acts as a get
        issue(OP_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);  // new key, demotes to a ghost
        issue(OP_PUT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        issue(OP_PUT, 32'h0000_0000, 32'h1111_1111);  // put on a ghost key
        issue(OP_PUT, 32'hFFFF_FFFF, 32'h2222_2222);
        issue(OP_PUT, 32'hA5A5_A5A5, 32'h3333_3333);
        issue(OP_PUT, 32'h0000_0000, 32'h4444_4444);  // put on a ghost key
        issue(OP_GET, 32'h5A5A_5A5A, 32'h0);       // get on a ghost misses
        issue(OP_ERASE, 32'h0000_0000, 32'h0);     // erase of a resident key
        issue(OP_ERASE, 32'h5A5A_5A5A, 32'h0);     // erase of a ghost key
        issue(OP_ERASE, 32'hDEAD_BEEF, 32'h0);     // erase of an absent key
        issue(OP_PUT, 32'h5A5A_5A5A, 32'h6666_6666);  // new key, cache not full
        issue(OP_PUT, 32'hFFFF_FFFF, 32'h7777_7777);
        issue(OP_PUT, 32'h0000_0001, 32'h8888_8888);
        issue(OP_PUT, 32'h8000_0000, 32'h9999_9999);
        drain();

        // Shrink to one entry with live contents; zero, which also acts as one, comes later.
        set_capacity(5'd1);
        issue(OP_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        issue(OP_PUT, 32'hF0F0_F0F0, 32'h0F0F_0F0F);
        issue(OP_GET, 32'h0F0F_0F0F, 32'h0);
        drain();

        random_phase(150, 6);
        drain();
        set_capacity(5'd4);
        random_phase(150, 12);
        drain();

        idle_pct = 47;
        set_capacity(5'd16);
        random_phase(150, 40);
        drain();
        set_capacity(5'd0);
        random_phase(120, 4);
        drain();

        idle_pct = 0;
        set_capacity(5'd31);
        random_phase(150, 40);
        drain();
        set_capacity(5'd3);
        random_phase(100, 8);
        drain();
        set_capacity(5'd17);
        random_phase(100, 36);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/arc_pkg.sv
hdl/arc_div.sv
hdl/arc_dir.sv
hdl/arc_replacement_cache.sv
sim/arc_checker.sv
sim/tb_top.sv
